### rtl/core/msh_pkg.sv
// Package for the multi-algorithm string hash: algorithm codes, register
// indexes, hash constants and the running-state struct.
// No dependencies.
package msh_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned AlgW    = 4;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [AlgW-1:0] {
    AlgRs   = 4'd0,
    AlgJs   = 4'd1,
    AlgPjw  = 4'd2,
    AlgElf  = 4'd3,
    AlgBkdr = 4'd4,
    AlgSdbm = 4'd5,
    AlgDjb  = 4'd6,
    AlgDek  = 4'd7,
    AlgAp   = 4'd8
  } alg_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlgSel   = 1'b0,
    CfgBkdrSeed = 1'b1
  } cfg_idx_e;

  localparam logic [HashW-1:0] RsB        = 32'd378551;
  localparam logic [HashW-1:0] RsA0       = 32'd63689;
  localparam logic [HashW-1:0] JsInit     = 32'd1315423911;
  localparam logic [HashW-1:0] NibbleHigh = 32'hF000_0000;
  localparam logic [HashW-1:0] BkdrReset  = 32'd131;
  localparam logic [HashW-1:0] DjbInit    = 32'd5381;
  localparam logic [HashW-1:0] ApInit     = 32'hAAAA_AAAA;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [HashW-1:0] rs_mult;
    logic             odd;
  } hash_state_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [HashW-1:0] length;
  } in_item_t;

endpackage

### rtl/core/msh_fold.sv
// One hash step: optional restart, then folds one byte into the running state
// with the selected algorithm. Combinational; one shared 32x32 multiplier plus the RS a*b update.
// Depends on msh_pkg.
module msh_fold
  import msh_pkg::*;
(
  input  logic [AlgW-1:0]  alg_i,
  input  logic [HashW-1:0] bkdr_seed_i,
  input  hash_state_t      cur_i,
  input  in_item_t         item_i,
  output hash_state_t      nxt_o
);

  logic [HashW-1:0] c;
  logic [HashW-1:0] start;
  logic [HashW-1:0] h0;
  logic [HashW-1:0] rs0;
  logic             odd0;
  logic [HashW-1:0] mul_a;
  logic [HashW-1:0] mul_b;
  logic [HashW-1:0] prod;
  logic [HashW-1:0] sh4;
  logic [HashW-1:0] top4;
  logic [HashW-1:0] h_new;
  logic [HashW-1:0] rs_new;

  assign c = {{24{item_i.data[7]}}, item_i.data};

  always_comb begin
    case (alg_i)
      AlgJs:   start = JsInit;
      AlgDjb:  start = DjbInit;
      AlgDek:  start = item_i.length;
      AlgAp:   start = ApInit;
      default: start = '0;
    endcase
  end

  assign h0   = item_i.first ? start : cur_i.hash;
  assign rs0  = item_i.first ? RsA0 : cur_i.rs_mult;
  assign odd0 = item_i.first ? 1'b0 : cur_i.odd;

  // shared multiplier: RS h*a, BKDR h*seed, AP c*(h>>3)
  always_comb begin
    case (alg_i)
      AlgRs: begin
        mul_a = h0;
        mul_b = rs0;
      end
      AlgBkdr: begin
        mul_a = h0;
        mul_b = bkdr_seed_i;
      end
      default: begin
        mul_a = c;
        mul_b = h0 >> 3;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sh4  = (h0 << 4) + c;
  assign top4 = sh4 & NibbleHigh;

  always_comb begin
    h_new  = h0;
    rs_new = rs0;
    case (alg_i)
      AlgRs: begin
        h_new  = prod + c;
        rs_new = rs0 * RsB;
      end
      AlgJs:   h_new = h0 ^ ((h0 << 5) + c + (h0 >> 2));
      AlgPjw: begin
        if (top4 != '0) begin
          h_new = (sh4 ^ (top4 >> 24)) & ~NibbleHigh;
        end else begin
          h_new = sh4;
        end
      end
      AlgElf:  h_new = (sh4 ^ (top4 >> 24)) & ~top4;
      AlgBkdr: h_new = prod + c;
      AlgSdbm: h_new = c + (h0 << 6) + (h0 << 16) - h0;
      AlgDjb:  h_new = (h0 << 5) + h0 + c;
      AlgDek:  h_new = ((h0 << 5) ^ (h0 >> 27)) ^ c;
      AlgAp: begin
        if (!odd0) begin
          h_new = h0 ^ ((h0 << 7) ^ prod);
        end else begin
          h_new = h0 ^ ~((h0 << 11) + (c ^ (h0 >> 5)));
        end
      end
      default: h_new = h0;
    endcase
  end

  assign nxt_o.hash    = h_new;
  assign nxt_o.rs_mult = rs_new;
  assign nxt_o.odd     = ~odd0;

endmodule

### rtl/core/multi_algorithm_string_hash_top.sv
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   data_byte_i, first_byte_i, last_byte_i, string_length_i
// out      out  out_valid_o / out_stall_i hash_value_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle while the input is not stalled. A byte is registered on
// accept and folded into the running hash as it leaves; a last byte's hash is then registered.
// The rate is set by the running-hash update loop (one multiply-add per cycle).
// Async active-low reset loads config, state and valid flags, not data registers; no clearing pass.
// A stalled result holds; a last byte then waits in the input register and
// stalls the input. Non-last bytes keep flowing. Depends on msh_pkg, msh_fold.
module multi_algorithm_string_hash_top
  import msh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [HashW-1:0]   string_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [HashW-1:0]   hash_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HashW-1:0]   cfg_data_i
);

  logic [AlgW-1:0]  alg_q;
  logic [HashW-1:0] seed_q;
  hash_state_t      st_q, st_d;
  in_item_t         item_q;
  logic             item_vld_q;
  logic             out_vld_q;
  logic [HashW-1:0] out_hash_q;
  logic             in_acc;
  logic             adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q  <= AlgRs;
      seed_q <= BkdrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAlgSel:   alg_q  <= cfg_data_i[AlgW-1:0];
        CfgBkdrSeed: seed_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign adv        = item_vld_q && !(item_q.last && out_vld_q && out_stall_i);
  assign in_stall_o = item_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_acc) begin
      item_vld_q <= 1'b1;
    end else if (adv) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.data   <= data_byte_i;
      item_q.first  <= first_byte_i;
      item_q.last   <= last_byte_i;
      item_q.length <= string_length_i;
    end
  end

  msh_fold u_fold (
    .alg_i      (alg_q),
    .bkdr_seed_i(seed_q),
    .cur_i      (st_q),
    .item_i     (item_q),
    .nxt_o      (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.hash    <= '0;
      st_q.rs_mult <= RsA0;
      st_q.odd     <= 1'b0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && item_q.last) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_q.last) begin
      out_hash_q <= st_d.hash;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hash_value_o = out_hash_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_vld_q && item_q.last && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_result_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_q.last) |=> (out_valid_o && hash_value_o == st_q.hash))
    else $error("emitted hash differs from running hash");

  a_first_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_q.first) |=> (st_q.odd && st_q.rs_mult == $past(st_d.rs_mult)))
    else $error("restart did not reset byte parity");

endmodule
